// File: rtl/core/indexed_min_heap_queue_defines.svh
// Assertion macros used by the heap queue RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define IMHQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define IMHQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define IMHQ_ASSERT(lbl, clk, rstn, prop, msg)
`define IMHQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: rtl/core/imhq_pkg.sv
// Package with command and status codes and helpers for the heap queue.
package imhq_pkg;

  localparam int unsigned DefCapacity    = 64;
  localparam int unsigned DefPayloadBits = 32;

  localparam logic [2:0] CmdAdd     = 3'd0;
  localparam logic [2:0] CmdSet     = 3'd1;
  localparam logic [2:0] CmdRemove  = 3'd2;
  localparam logic [2:0] CmdSearch  = 3'd3;
  localparam logic [2:0] CmdMin     = 3'd4;
  localparam logic [2:0] CmdMax     = 3'd5;
  localparam logic [2:0] CmdExtract = 3'd6;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StExists = 3'd1;
  localparam logic [2:0] StNoKey  = 3'd2;
  localparam logic [2:0] StEmpty  = 3'd3;
  localparam logic [2:0] StFull   = 3'd4;

  // Signed key ordering.
  function automatic logic key_less(logic signed [63:0] a, logic signed [63:0] b);
    return a < b;
  endfunction

endpackage

// File: rtl/core/imhq_mem.sv
// Slot memory: one write port, one read port with registered read data.
module imhq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// File: rtl/core/indexed_min_heap_queue.sv
// Indexed binary min-heap priority queue, one transaction at a time.
// Key lookup scans occupied slots in turn, a read then a compare per slot; each sift level
// is a read then a compare, with a second read for a right child. An unused command or an
// empty heap goes straight to completion, and min reads only the root. A finished result
// waits for out_ready_i, and a new transaction is taken only from idle, after the result.
// Reset clears the entry count and the handshake state; slot memory contents are not cleared.
`include "indexed_min_heap_queue_defines.svh"
module indexed_min_heap_queue import imhq_pkg::*; #(
  parameter int unsigned CAPACITY     = DefCapacity,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [63:0] item_key_i,
  input  logic [31:0]        item_payload_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [63:0] out_key_o,
  output logic [5:0]         slot_index_o,
  output logic [31:0]        out_payload_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned PW = PAYLOAD_BITS;
  localparam int unsigned EW = 64 + PW;

  localparam logic [4:0] SIdle    = 5'd0;
  localparam logic [4:0] SScanRd  = 5'd1;
  localparam logic [4:0] SScanCmp = 5'd2;
  localparam logic [4:0] SRmLast  = 5'd3;
  localparam logic [4:0] SRmLoad  = 5'd4;
  localparam logic [4:0] SUpRd    = 5'd5;
  localparam logic [4:0] SUpCmp   = 5'd6;
  localparam logic [4:0] SDnRdL   = 5'd7;
  localparam logic [4:0] SDnGetL  = 5'd8;
  localparam logic [4:0] SDnGetR  = 5'd9;
  localparam logic [4:0] SWb      = 5'd10;
  localparam logic [4:0] SSetWr   = 5'd11;
  localparam logic [4:0] SRootGet = 5'd12;
  localparam logic [4:0] SMaxRd   = 5'd13;
  localparam logic [4:0] SMaxCmp  = 5'd14;
  localparam logic [4:0] SDone    = 5'd15;

  logic [4:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [2:0]         cmd_q, cmd_d;
  logic signed [63:0] key_q, key_d;
  logic [PW-1:0]      pay_q, pay_d;
  logic signed [63:0] ck_q, ck_d;
  logic [PW-1:0]      cp_q, cp_d;
  logic signed [63:0] bk_q, bk_d;
  logic [PW-1:0]      bp_q, bp_d;
  logic [AW-1:0]      bidx_q, bidx_d;
  logic [2:0]         res_st_q, res_st_d;
  logic signed [63:0] res_key_q, res_key_d;
  logic [AW-1:0]      res_slot_q, res_slot_d;
  logic [PW-1:0]      res_pay_q, res_pay_d;

  logic               ov_q;
  logic [2:0]         o_st_q;
  logic signed [63:0] o_key_q;
  logic [5:0]         o_slot_q;
  logic [31:0]        o_pay_q;

  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [EW-1:0]      wr_data, rd_data;
  logic signed [63:0] rd_key;
  logic [PW-1:0]      rd_pay;
  logic [IW-1:0]      lchild, rchild, cnt_x;
  logic [AW-1:0]      parent;
  logic [CW-1:0]      last;
  logic               out_free;

  assign rd_key   = rd_data[EW-1:PW];
  assign rd_pay   = rd_data[PW-1:0];
  assign lchild   = {1'b0, pos_q, 1'b1};
  assign rchild   = lchild + IW'(1);
  assign cnt_x    = IW'(cnt_q);
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign last     = cnt_q - CW'(1);
  assign out_free = !ov_q || out_ready_i;

  imhq_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer for lookup, sift and scan steps.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    pay_d      = pay_q;
    ck_d       = ck_q;
    cp_d       = cp_q;
    bk_d       = bk_q;
    bp_d       = bp_q;
    bidx_d     = bidx_q;
    res_st_d   = res_st_q;
    res_key_d  = res_key_q;
    res_slot_d = res_slot_q;
    res_pay_d  = res_pay_q;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = {ck_q, cp_q};
    rd_addr    = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_d      = cmd_i;
          key_d      = item_key_i;
          pay_d      = PW'(item_payload_i);
          idx_d      = '0;
          res_st_d   = StOk;
          res_key_d  = '0;
          res_slot_d = '0;
          res_pay_d  = '0;
          if (cmd_i == CmdAdd || cmd_i == CmdSet || cmd_i == CmdRemove ||
              cmd_i == CmdSearch) begin
            state_d = SScanRd;
          end else if (cmd_i == CmdMin || cmd_i == CmdMax || cmd_i == CmdExtract) begin
            if (cnt_q == '0) begin
              res_st_d = StEmpty;
              state_d  = SDone;
            end else begin
              state_d = SRootGet;
            end
          end else begin
            res_st_d = StNoKey;
            state_d  = SDone;
          end
        end
      end
      SScanRd: begin
        rd_addr = idx_q[AW-1:0];
        if (idx_q == cnt_q) begin
          if (cmd_q != CmdAdd) begin
            res_st_d = StNoKey;
            state_d  = SDone;
          end else if (cnt_q == CW'(CAPACITY)) begin
            res_st_d = StFull;
            state_d  = SDone;
          end else begin
            pos_d   = cnt_q[AW-1:0];
            ck_d    = key_q;
            cp_d    = pay_q;
            cnt_d   = cnt_q + CW'(1);
            state_d = SUpRd;
          end
        end else begin
          state_d = SScanCmp;
        end
      end
      SScanCmp: begin
        if (rd_key == key_q) begin
          unique case (cmd_q)
            CmdAdd: begin
              res_st_d = StExists;
              state_d  = SDone;
            end
            CmdSet: state_d = SSetWr;
            CmdSearch: begin
              res_slot_d = idx_q[AW-1:0];
              res_pay_d  = rd_pay;
              state_d    = SDone;
            end
            default: begin
              cnt_d = last;
              pos_d = idx_q[AW-1:0];
              state_d = (idx_q == last) ? SDone : SRmLast;
            end
          endcase
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = SScanRd;
        end
      end
      SSetWr: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0];
        wr_data = {key_q, pay_q};
        state_d = SDone;
      end
      SRmLast: begin
        rd_addr = cnt_q[AW-1:0];
        state_d = SRmLoad;
      end
      SRmLoad: begin
        ck_d    = rd_key;
        cp_d    = rd_pay;
        state_d = key_less(key_q, rd_key) ? SDnRdL : SUpRd;
      end
      SUpRd: begin
        rd_addr = parent;
        state_d = (pos_q == '0) ? SWb : SUpCmp;
      end
      SUpCmp: begin
        if (key_less(ck_q, rd_key)) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_d   = parent;
          state_d = SUpRd;
        end else begin
          state_d = SWb;
        end
      end
      SDnRdL: begin
        rd_addr = lchild[AW-1:0];
        state_d = (CW'(pos_q) < (cnt_q >> 1)) ? SDnGetL : SWb;
      end
      SDnGetL: begin
        bk_d    = rd_key;
        bp_d    = rd_pay;
        bidx_d  = lchild[AW-1:0];
        rd_addr = rchild[AW-1:0];
        if (rchild < cnt_x) begin
          state_d = SDnGetR;
        end else if (key_less(rd_key, ck_q)) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_d   = lchild[AW-1:0];
          state_d = SDnRdL;
        end else begin
          state_d = SWb;
        end
      end
      SDnGetR: begin
        if (key_less(rd_key, bk_q)) begin
          if (key_less(rd_key, ck_q)) begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            pos_d   = rchild[AW-1:0];
            state_d = SDnRdL;
          end else begin
            state_d = SWb;
          end
        end else if (key_less(bk_q, ck_q)) begin
          wr_en   = 1'b1;
          wr_data = {bk_q, bp_q};
          pos_d   = bidx_q;
          state_d = SDnRdL;
        end else begin
          state_d = SWb;
        end
      end
      SWb: begin
        wr_en   = 1'b1;
        state_d = SDone;
      end
      SRootGet: begin
        rd_addr = last[AW-1:0];
        unique case (cmd_q)
          CmdMin: begin
            res_key_d = rd_key;
            res_pay_d = rd_pay;
            state_d   = SDone;
          end
          CmdMax: begin
            bk_d    = rd_key;
            bp_d    = rd_pay;
            bidx_d  = '0;
            idx_d   = cnt_q >> 1;
            state_d = SMaxRd;
          end
          default: begin
            res_key_d = rd_key;
            res_pay_d = rd_pay;
            key_d     = rd_key;
            pos_d     = '0;
            cnt_d     = last;
            state_d   = (last == '0) ? SDone : SRmLoad;
          end
        endcase
      end
      SMaxRd: begin
        rd_addr = idx_q[AW-1:0];
        if (idx_q == cnt_q) begin
          res_key_d  = bk_q;
          res_pay_d  = bp_q;
          res_slot_d = bidx_q;
          state_d    = SDone;
        end else begin
          state_d = SMaxCmp;
        end
      end
      SMaxCmp: begin
        if (key_less(bk_q, rd_key)) begin
          bk_d   = rd_key;
          bp_d   = rd_pay;
          bidx_d = idx_q[AW-1:0];
        end
        idx_d   = idx_q + CW'(1);
        state_d = SMaxRd;
      end
      SDone: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == SDone && out_free) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    pay_q      <= pay_d;
    ck_q       <= ck_d;
    cp_q       <= cp_d;
    bk_q       <= bk_d;
    bp_q       <= bp_d;
    bidx_q     <= bidx_d;
    res_st_q   <= res_st_d;
    res_key_q  <= res_key_d;
    res_slot_q <= res_slot_d;
    res_pay_q  <= res_pay_d;
    if (state_q == SDone && out_free) begin
      o_st_q   <= res_st_q;
      o_key_q  <= res_key_q;
      o_slot_q <= 6'(res_slot_q);
      o_pay_q  <= 32'(res_pay_q);
    end
  end

  assign in_ready_o    = (state_q == SIdle);
  assign out_valid_o   = ov_q;
  assign status_o      = o_st_q;
  assign out_key_o     = o_key_q;
  assign slot_index_o  = o_slot_q;
  assign out_payload_o = o_pay_q;

  `IMHQ_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CW'(CAPACITY), "entry count above capacity")
  `IMHQ_ASSERT_NEVER(a_no_wr_idle, clk_i, rst_ni, wr_en && state_q == SIdle, "slot write while idle")
  `IMHQ_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(ov_q) |-> $past(state_q == SDone), "result without completion")

endmodule
